// ===== design/itra_pkg.sv =====
`default_nettype none

package itra_pkg;

    // value and field widths
    localparam int VALUE_W    = 32;
    localparam int CFG_W      = 6;
    localparam int CHAR_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 1;

    // limits on the configuration
    localparam logic [CFG_W-1:0] MIN_RADIX   = CFG_W'(2);
    localparam logic [CFG_W-1:0] MAX_RADIX   = CFG_W'(36);
    localparam logic [CFG_W-1:0] MIN_BUF_LEN = CFG_W'(2);

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] RADIX_RESET   = CFG_W'(10);
    localparam logic [CFG_W-1:0] BUF_LEN_RESET = CFG_W'(10);

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_RADIX   = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_BUF_LEN = CFG_ADDR_W'(1);

    // divider: DIV_BITS quotient bits per cycle, dividend padded to whole steps
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = (VALUE_W + DIV_BITS - 1) / DIV_BITS;
    localparam int PAD_W     = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);
    localparam int REM_W     = CFG_W + 1;

    // digit store
    localparam int COUNT_W = $clog2(VALUE_W + 1);
    localparam int ADDR_W  = $clog2(VALUE_W);
    localparam int CMP_W   = ((COUNT_W > CFG_W) ? COUNT_W : CFG_W) + 1;

    // request queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // characters
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER = 8'h61;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_BAD_CFG = 2'd1,
        ST_NO_FIT  = 2'd2
    } t_status;

    typedef struct packed {
        logic [CFG_W-1:0] radix;
        logic [CFG_W-1:0] buf_len;
    } t_cfg;

    typedef struct packed {
        logic               bad_cfg;
        logic               negative;
        logic [VALUE_W-1:0] magnitude;
    } t_req;

    // digit value to lower-case ASCII
    function automatic logic [CHAR_W-1:0] digit_char(input logic [CFG_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < CFG_W'(10)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else if (d < MAX_RADIX) begin
            c = CHAR_LOWER + CHAR_W'(d) - CHAR_W'(10);
        end else begin
            c = CHAR_ZERO;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/itra_front.sv =====
`default_nettype none

module itra_front (
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [itra_pkg::VALUE_W-1:0] i_value,
    input  wire itra_pkg::t_cfg                 i_cfg,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output itra_pkg::t_req                      o_req
);
    import itra_pkg::*;

    logic               bad_cfg;
    logic               negative;
    logic [VALUE_W-1:0] raw;

    assign busy = i_q_full;
    assign o_push = start && !i_q_full;

    // bad base or length is decided here; the back end only reports it
    assign bad_cfg = (i_cfg.radix < MIN_RADIX) || (i_cfg.radix > MAX_RADIX)
                     || (i_cfg.buf_len < MIN_BUF_LEN);

    assign raw      = i_value;
    assign negative = raw[VALUE_W-1];

    // unsigned magnitude; the most negative value maps onto itself
    assign o_req.bad_cfg   = bad_cfg;
    assign o_req.negative  = negative;
    assign o_req.magnitude = negative ? (~raw + VALUE_W'(1)) : raw;

endmodule

`default_nettype wire

// ===== design/itra_queue.sv =====
`default_nettype none

module itra_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire itra_pkg::t_req i_req,
    input  wire logic           i_pop,
    output itra_pkg::t_req      o_req,
    output logic                o_full,
    output logic                o_empty
);
    import itra_pkg::*;

    t_req              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr_ptr;
    logic [QPTR_W-1:0] n_rd_ptr;
    logic [QCNT_W-1:0] n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_req   = r_slot[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

// ===== design/itra_back.sv =====
`default_nettype none

module itra_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire itra_pkg::t_cfg              i_cfg,
    input  wire itra_pkg::t_req              i_req,
    input  wire logic                        i_q_empty,
    output logic                             o_pop,
    output logic                             o_valid,
    output logic [itra_pkg::CHAR_W-1:0]      o_char_code,
    output logic                             o_is_last,
    output logic [itra_pkg::STATUS_W-1:0]    o_status
);
    import itra_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_CHECK = 6'b000100,
        S_SIGN  = 6'b001000,
        S_PRIME = 6'b010000,
        S_DIGIT = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [PAD_W-1:0]   r_mag, n_mag;
    logic [CFG_W-1:0]   r_rem, n_rem;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [COUNT_W-1:0] r_cnt, n_cnt;
    logic [COUNT_W-1:0] r_left, n_left;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic               r_neg, n_neg;
    logic               r_valid, n_valid;
    logic [CHAR_W-1:0]  r_char, n_char;
    logic               r_last, n_last;
    t_status            r_status, n_status;

    logic [CFG_W-1:0]   r_store [VALUE_W];
    logic [CFG_W-1:0]   r_rd_data;
    logic               store_we;

    // divider step: DIV_BITS restoring iterations on the remainder
    logic [PAD_W-1:0]   step_mag;
    logic [CFG_W-1:0]   step_rem;
    logic [REM_W-1:0]   trial;
    logic [CMP_W-1:0]   text_len;
    logic               no_fit;

    always_comb begin
        step_mag = r_mag;
        step_rem = r_rem;
        trial    = '0;
        for (int j = 0; j < DIV_BITS; j++) begin
            trial = {step_rem, step_mag[PAD_W-1]};
            if (trial >= {1'b0, i_cfg.radix}) begin
                trial    = trial - {1'b0, i_cfg.radix};
                step_mag = {step_mag[PAD_W-2:0], 1'b1};
            end else begin
                step_mag = {step_mag[PAD_W-2:0], 1'b0};
            end
            step_rem = trial[CFG_W-1:0];
        end
    end

    // sign plus digits plus terminator must fit the buffer
    assign text_len = CMP_W'(r_cnt) + CMP_W'(r_neg) + CMP_W'(1);
    assign no_fit   = text_len > CMP_W'(i_cfg.buf_len);

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_rem    = r_rem;
        n_step   = r_step;
        n_cnt    = r_cnt;
        n_left   = r_left;
        n_addr   = r_addr;
        n_neg    = r_neg;
        n_valid  = 1'b0;
        n_char   = r_char;
        n_last   = r_last;
        n_status = r_status;
        o_pop    = 1'b0;
        store_we = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    if (i_req.bad_cfg) begin
                        n_valid  = 1'b1;
                        n_char   = CHAR_NUL;
                        n_last   = 1'b1;
                        n_status = ST_BAD_CFG;
                    end else begin
                        n_mag   = PAD_W'(i_req.magnitude);
                        n_neg   = i_req.negative;
                        n_rem   = '0;
                        n_step  = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_mag  = step_mag;
                n_rem  = step_rem;
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    // digit done: store it, restart on the quotient
                    store_we = 1'b1;
                    n_cnt    = r_cnt + COUNT_W'(1);
                    n_step   = '0;
                    n_rem    = '0;
                    if (step_mag == '0) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (no_fit) begin
                    n_valid  = 1'b1;
                    n_char   = CHAR_NUL;
                    n_last   = 1'b1;
                    n_status = ST_NO_FIT;
                    n_state  = S_IDLE;
                end else begin
                    n_left  = r_cnt - COUNT_W'(1);
                    n_addr  = n_left[ADDR_W-1:0];
                    n_state = r_neg ? S_SIGN : S_PRIME;
                end
            end
            S_SIGN: begin
                n_valid  = 1'b1;
                n_char   = CHAR_MINUS;
                n_last   = 1'b0;
                n_status = ST_OK;
                n_addr   = r_addr - ADDR_W'(1);
                n_state  = S_DIGIT;
            end
            S_PRIME: begin
                // wait for the registered store read
                n_addr  = r_addr - ADDR_W'(1);
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                n_valid  = 1'b1;
                n_char   = digit_char(r_rd_data);
                n_last   = (r_left == '0);
                n_status = ST_OK;
                n_addr   = r_addr - ADDR_W'(1);
                n_left   = r_left - COUNT_W'(1);
                if (r_left == '0) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_step  <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
            r_neg   <= 1'b0;
            r_mag   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_addr   <= n_addr;
        r_char   <= n_char;
        r_last   <= n_last;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_cnt[ADDR_W-1:0]] <= step_rem;
        end
        r_rd_data <= r_store[r_addr];
    end

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_is_last   = r_last;
    assign o_status    = r_status;

endmodule

`default_nettype wire

// ===== design/integer_to_radix_ascii.sv =====
`default_nettype none
// Channel   Handshake                 Payload
// request   start in, busy out        i_value
// result    o_valid strobe, 1 cycle   o_char_code, o_is_last, o_status
// config    i_cfg_we                  i_cfg_addr, i_cfg_wdata
//
// A request is taken when start is high and busy is low; two requests queue ahead
// of the converter. Each digit is divided out DIV_BITS quotient bits at a time;
// a check state and a store-read state, which carries any '-', then lead the
// digits at one per cycle. A bad base or length gives its status result the cycle
// after the pop. Reset is synchronous, active low, and restores radix 10 and buffer
// length 10. Results cannot be held off.

module integer_to_radix_ascii (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [itra_pkg::VALUE_W-1:0] i_value,
    output logic                                     o_valid,
    output logic [itra_pkg::CHAR_W-1:0]              o_char_code,
    output logic                                     o_is_last,
    output logic [itra_pkg::STATUS_W-1:0]            o_status,
    input  wire logic                                i_cfg_we,
    input  wire logic [itra_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [itra_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import itra_pkg::*;

    t_cfg r_cfg;
    t_req front_req;
    t_req queue_req;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.radix   <= RADIX_RESET;
            r_cfg.buf_len <= BUF_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_RADIX:   r_cfg.radix   <= i_cfg_wdata;
                REG_BUF_LEN: r_cfg.buf_len <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    itra_front u_front (
        .start    (start),
        .busy     (busy),
        .i_value  (i_value),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_req    (front_req)
    );

    itra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_req   (queue_req),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    itra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_req       (queue_req),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last),
        .o_status    (o_status)
    );

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import itra_pkg::*;

    // longest correct silence is one base-2 conversion
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 15;
    localparam int PHASE_ITEMS   = 30;
    localparam int QUIET_PHASES  = 3;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        t_status           status;
    } t_text_char;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    logic signed [VALUE_W-1:0]   i_value;
    logic                        o_valid;
    logic [CHAR_W-1:0]           o_char_code;
    logic                        o_is_last;
    logic [STATUS_W-1:0]         o_status;
    logic                        i_cfg_we;
    logic [CFG_ADDR_W-1:0]       i_cfg_addr;
    logic [CFG_W-1:0]            i_cfg_wdata;

    // shadow copy of the configuration registers
    logic [CFG_W-1:0] cfg_radix;
    logic [CFG_W-1:0] cfg_buf_len;

    t_text_char expected_chars[$];

    int mismatch_count;
    int results_seen;
    int values_sent;
    int settings_used;
    int text_requests;
    int bad_cfg_requests;
    int no_fit_requests;
    int idle_cycles;

    integer_to_radix_ascii DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_is_last   (o_is_last),
        .o_status    (o_status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    // expected characters of one request under the current settings
    task automatic predict_text(input logic [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] mag;
        logic [CFG_W-1:0]   digits [VALUE_W];
        logic               neg;
        int                 ndig;
        t_text_char         c;
        if (cfg_radix < MIN_RADIX || cfg_radix > MAX_RADIX || cfg_buf_len < MIN_BUF_LEN) begin
            c = '{code: CHAR_NUL, last: 1'b1, status: ST_BAD_CFG};
            expected_chars.push_back(c);
            bad_cfg_requests++;
        end else begin
            neg  = value[VALUE_W-1];
            mag  = neg ? -value : value;
            ndig = 0;
            do begin
                digits[ndig] = CFG_W'(mag % VALUE_W'(cfg_radix));
                mag          = mag / VALUE_W'(cfg_radix);
                ndig++;
            end while (mag != '0);
            // room is needed for the terminator as well
            if (ndig + int'(neg) + 1 > int'(cfg_buf_len)) begin
                c = '{code: CHAR_NUL, last: 1'b1, status: ST_NO_FIT};
                expected_chars.push_back(c);
                no_fit_requests++;
            end else begin
                if (neg) begin
                    c = '{code: CHAR_MINUS, last: 1'b0, status: ST_OK};
                    expected_chars.push_back(c);
                end
                for (int i = ndig - 1; i >= 0; i--) begin
                    c.code   = (digits[i] < CFG_W'(10))
                             ? CHAR_ZERO + CHAR_W'(digits[i])
                             : CHAR_LOWER + CHAR_W'(digits[i]) - CHAR_W'(10);
                    c.last   = (i == 0);
                    c.status = ST_OK;
                    expected_chars.push_back(c);
                end
                text_requests++;
            end
        end
    endtask

    // present one request and hold it until taken; returns at the accepting edge
    task automatic send_value(input logic [VALUE_W-1:0] value);
        logic taken;
        start   <= 1'b1;
        i_value <= value;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            if (taken) begin
                predict_text(value);
            end
            @(posedge i_clk);
        end
        values_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] radix, input logic [CFG_W-1:0] buf_len);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_RADIX;
        i_cfg_wdata <= radix;
        @(posedge i_clk);
        i_cfg_addr  <= REG_BUF_LEN;
        i_cfg_wdata <= buf_len;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_radix   = radix;
        cfg_buf_len = buf_len;
        settings_used++;
        @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0]        p;
        logic [VALUE_W-1:0] v;
        int                 kind;
        int                 r;
        kind = $urandom_range(0, 9);
        case (kind)
            0, 1, 2, 3: begin
                v = $urandom();
            end
            4, 5, 6: begin
                v = $urandom_range(0, 2000);
            end
            7: begin
                // land next to a power of the base, where the digit count steps
                r = (cfg_radix >= MIN_RADIX && cfg_radix <= MAX_RADIX) ? int'(cfg_radix) : 10;
                p = 64'd1;
                repeat ($urandom_range(1, 31)) begin
                    if (p * r < 64'h8000_0000) begin
                        p = p * r;
                    end
                end
                v = VALUE_W'(p) + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
            end
            8: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7fff_ffff;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: begin
                v = $urandom() >> $urandom_range(0, 31);
            end
        endcase
        if (kind >= 4 && kind != 8 && $urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    task automatic test_reset_settings();
        send_value(32'd0);
        send_value(32'd1);
        send_value(-32'sd1);
        send_value(32'd123456789);
        send_value(-32'sd12345678);
        send_value(32'd1234567890);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
    endtask

    task automatic test_base_extremes();
        set_config(CFG_W'(2), CFG_W'(63));
        send_value(32'h8000_0000);
        send_value(32'h7fff_ffff);
        send_value(-32'sd1);
        send_value(32'd0);
        set_config(CFG_W'(36), CFG_W'(63));
        send_value(32'd35);
        send_value(-32'sd36);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
    endtask

    task automatic test_bad_settings();
        set_config(CFG_W'(0), CFG_W'(10));
        send_value(32'd5);
        set_config(CFG_W'(1), CFG_W'(63));
        send_value(-32'sd5);
        set_config(CFG_W'(37), CFG_W'(63));
        send_value(32'd7);
        set_config(CFG_W'(63), CFG_W'(63));
        send_value(32'd0);
        set_config(CFG_W'(10), CFG_W'(0));
        send_value(32'd3);
        set_config(CFG_W'(10), CFG_W'(1));
        send_value(-32'sd3);
    endtask

    task automatic test_tight_buffer();
        set_config(CFG_W'(10), CFG_W'(2));
        send_value(32'd7);
        send_value(-32'sd7);
        send_value(32'd10);
    endtask

    task automatic test_random_traffic();
        logic [CFG_W-1:0] radix;
        logic [CFG_W-1:0] buf_len;
        int               pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                radix = CFG_W'($urandom_range(0, 63));
            end else if (pick == 1) begin
                radix = MIN_RADIX;
            end else if (pick == 2) begin
                radix = MAX_RADIX;
            end else begin
                radix = CFG_W'($urandom_range(2, 36));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                buf_len = CFG_W'($urandom_range(0, 63));
            end else if (pick <= 3) begin
                buf_len = CFG_W'($urandom_range(2, 33));
            end else begin
                buf_len = CFG_W'($urandom_range(34, 63));
            end
            set_config(radix, buf_len);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_value(pick_value());
                // leave the final phases back to back
                if (phase < RANDOM_PHASES - QUIET_PHASES && $urandom_range(0, 2) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 5)) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin : result_check
        t_text_char want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid) begin
                results_seen++;
                if (expected_chars.size() == 0) begin
                    note_mismatch($sformatf("unexpected result char %02h last %0b status %0d",
                                            o_char_code, o_is_last, o_status));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_char_code !== want.code || o_is_last !== want.last
                            || o_status !== want.status) begin
                        note_mismatch($sformatf(
                            "result %0d: expected char %02h last %0b status %0d, got char %02h last %0b status %0d",
                            results_seen, want.code, want.last, want.status,
                            o_char_code, o_is_last, o_status));
                    end
                end
            end
            if ((start && !busy) || o_valid || !i_rst_n) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("watchdog: no request or result for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_chars.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        mismatch_count   = 0;
        results_seen     = 0;
        values_sent      = 0;
        settings_used    = 0;
        text_requests    = 0;
        bad_cfg_requests = 0;
        no_fit_requests  = 0;
        idle_cycles      = 0;
        cfg_radix        = RADIX_RESET;
        cfg_buf_len      = BUF_LEN_RESET;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_value     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= REG_RADIX;
        i_cfg_wdata <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_settings();
        test_base_extremes();
        test_bad_settings();
        test_tight_buffer();
        test_random_traffic();
        drain_results();

        $display("Converted %0d values under %0d register settings, %0d characters checked",
                 values_sent, settings_used, results_seen);
        $display("  %0d texts, %0d bad-setting and %0d overflow rejections",
                 text_requests, bad_cfg_requests, no_fit_requests);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches in total", mismatch_count);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== integer_to_radix_ascii.f =====
design/itra_pkg.sv
design/itra_front.sv
design/itra_queue.sv
design/itra_back.sv
design/integer_to_radix_ascii.sv
verif/tb_top.sv
